// File: sv/hmmv_pkg.sv
// Shared types, codes and the saturating cost add for the HMM Viterbi metric update.
// Used by hmmv_ctrl, hmmv_datapath and hmm_viterbi_metric_update_core.
// No dependencies.
package hmmv_pkg;

  localparam int unsigned COST_W = 20;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned OP_W   = 3;
  localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_START = 3'd0,
    OP_LOAD_TRANS = 3'd1,
    OP_LOAD_EMIT  = 3'd2,
    OP_FIRST_SYM  = 3'd3,
    OP_NEXT_SYM   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_RUN,
    CTL_DRAIN,
    CTL_COMMIT,
    CTL_REPORT
  } ctl_state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  from_state;
    logic [IDX_W-1:0]  to_state;
    logic [IDX_W-1:0]  symbol;
    logic [COST_W-1:0] cost;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  state_index;
    logic [COST_W-1:0] metric;
    logic              last;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             wr_start;
    logic             wr_trans;
    logic             wr_emit;
    logic             latch_sym;
    logic             issue;
    logic             seed;
    logic             first_col;
    logic             last_col;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             commit;
    logic             out_load;
    logic [IDX_W-1:0] out_idx;
    logic             out_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } sts_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, COST_INF}) begin
      return COST_INF;
    end
    return s[COST_W-1:0];
  endfunction

endpackage

// File: sv/hmmv_datapath.sv
// Datapath: cost tables, path metrics, add-compare-select pipeline, result register.
// Depends on hmmv_pkg; driven by hmmv_ctrl through cmd_t, reports through sts_t.
module hmmv_datapath import hmmv_pkg::*; #(
  parameter int unsigned NUM_STATES  = 4,
  parameter int unsigned NUM_SYMBOLS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  localparam int unsigned SW       = $clog2(NUM_STATES);
  localparam int unsigned SYW      = $clog2(NUM_SYMBOLS);
  localparam int unsigned TR_DEPTH = NUM_STATES * NUM_STATES;
  localparam int unsigned TR_AW    = $clog2(TR_DEPTH);
  localparam int unsigned EM_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int unsigned EM_AW    = $clog2(EM_DEPTH);

  logic [COST_W-1:0] start_q [NUM_STATES];
  logic [COST_W-1:0] pm_q    [NUM_STATES];
  logic [COST_W-1:0] nxt_q   [NUM_STATES];

  logic [COST_W-1:0] tr_mem [TR_DEPTH];
  logic [TR_DEPTH-1:0] tr_vld_q;
  logic [COST_W-1:0] em_mem [EM_DEPTH];
  logic [EM_DEPTH-1:0] em_vld_q;

  logic [SW-1:0]  wr_to_s, wr_from_s, row_s, col_s, out_idx_s;
  logic [SYW-1:0] wr_sym_s;
  logic [TR_AW-1:0] tr_waddr, tr_raddr;
  logic [EM_AW-1:0] em_waddr, em_raddr;

  logic [SYW-1:0] sym_q;
  logic           sym_ok_q;

  // stage 1: table reads
  logic              s1_vld_q, s1_first_q, s1_last_q, s1_seed_q;
  logic [SW-1:0]     s1_row_q;
  logic [COST_W-1:0] a_q, tr_rd_q, em_rd_q;
  logic              tr_rv_q, em_rv_q;
  logic [COST_W-1:0] b1, e1;
  // stage 2: path plus transition
  logic              s2_vld_q, s2_first_q, s2_last_q;
  logic [SW-1:0]     s2_row_q;
  logic [COST_W-1:0] c_q, e2_q;
  // stage 3: running minimum
  logic              s3_vld_q;
  logic [SW-1:0]     s3_row_q;
  logic [COST_W-1:0] best_q, e3_q;

  logic      out_valid_q;
  out_word_t out_word_q;

  assign wr_to_s   = in_word_i.to_state[SW-1:0];
  assign wr_from_s = in_word_i.from_state[SW-1:0];
  assign wr_sym_s  = in_word_i.symbol[SYW-1:0];
  assign row_s     = cmd_i.row[SW-1:0];
  assign col_s     = cmd_i.col[SW-1:0];
  assign out_idx_s = cmd_i.out_idx[SW-1:0];

  assign tr_waddr = TR_AW'(TR_AW'(wr_from_s) * TR_AW'(NUM_STATES)) + TR_AW'(wr_to_s);
  assign tr_raddr = TR_AW'(TR_AW'(col_s) * TR_AW'(NUM_STATES)) + TR_AW'(row_s);
  assign em_waddr = EM_AW'(EM_AW'(wr_to_s) * EM_AW'(NUM_SYMBOLS)) + EM_AW'(wr_sym_s);
  assign em_raddr = EM_AW'(EM_AW'(row_s) * EM_AW'(NUM_SYMBOLS)) + EM_AW'(sym_q);

  // start costs and path metrics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NUM_STATES; n++) begin
        start_q[n] <= COST_INF;
        pm_q[n]    <= COST_INF;
      end
    end else begin
      if (cmd_i.wr_start) begin
        start_q[wr_to_s] <= in_word_i.cost;
      end
      if (cmd_i.commit) begin
        pm_q <= nxt_q;
      end
    end
  end

  // transition and emission memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_trans) begin
      tr_mem[tr_waddr] <= in_word_i.cost;
    end
    tr_rd_q <= tr_mem[tr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_emit) begin
      em_mem[em_waddr] <= in_word_i.cost;
    end
    em_rd_q <= em_mem[em_raddr];
  end

  // an entry never written reads as unreachable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_vld_q <= '0;
      em_vld_q <= '0;
      tr_rv_q  <= 1'b0;
      em_rv_q  <= 1'b0;
    end else begin
      if (cmd_i.wr_trans) begin
        tr_vld_q[tr_waddr] <= 1'b1;
      end
      if (cmd_i.wr_emit) begin
        em_vld_q[em_waddr] <= 1'b1;
      end
      tr_rv_q <= tr_vld_q[tr_raddr];
      em_rv_q <= em_vld_q[em_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_sym) begin
      sym_q    <= wr_sym_s;
      sym_ok_q <= {1'b0, in_word_i.symbol} < (IDX_W + 1)'(NUM_SYMBOLS);
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q && s2_last_q;
    end
  end

  assign b1 = s1_seed_q ? '0 : (tr_rv_q ? tr_rd_q : COST_INF);
  assign e1 = (em_rv_q && sym_ok_q) ? em_rd_q : COST_INF;

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first_col;
    s1_last_q  <= cmd_i.last_col;
    s1_seed_q  <= cmd_i.seed;
    s1_row_q   <= row_s;
    a_q        <= cmd_i.seed ? start_q[row_s] : pm_q[col_s];

    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_row_q   <= s1_row_q;
    c_q        <= sat_add(a_q, b1);
    e2_q       <= e1;

    if (s2_vld_q) begin
      best_q <= (s2_first_q || (c_q < best_q)) ? c_q : best_q;
    end
    s3_row_q <= s2_row_q;
    e3_q     <= e2_q;

    if (s3_vld_q) begin
      nxt_q[s3_row_q] <= sat_add(best_q, e3_q);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q.state_index <= cmd_i.out_idx;
      out_word_q.metric      <= pm_q[out_idx_s];
      out_word_q.last        <= cmd_i.out_last;
    end
  end

  assign sts_o.pipe_busy = s1_vld_q || s2_vld_q || s3_vld_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_word_q;

endmodule

// File: sv/hmmv_ctrl.sv
// Controller: accepts input words, sequences table loads, the state-pair sweep and reporting.
// Depends on hmmv_pkg; drives hmmv_datapath through cmd_t.
module hmmv_ctrl import hmmv_pkg::*; #(
  parameter int unsigned NUM_STATES  = 4,
  parameter int unsigned NUM_SYMBOLS = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  input  sts_t     sts_i,
  output cmd_t     cmd_o
);

  localparam int unsigned SW  = $clog2(NUM_STATES);
  localparam int unsigned CHK = IDX_W + 1;

  ctl_state_e state_q, state_d;
  logic [SW-1:0] row_q, col_q;
  logic          seed_q;

  logic accept, is_sym_op, to_ok, from_ok, sym_ok, last_col, last_row, last_issue;
  op_e  op;

  assign op        = op_e'(in_word_i.operation);
  assign accept    = in_valid_i && (state_q == CTL_IDLE);
  assign is_sym_op = (op == OP_FIRST_SYM) || (op == OP_NEXT_SYM);
  assign to_ok     = {1'b0, in_word_i.to_state}   < CHK'(NUM_STATES);
  assign from_ok   = {1'b0, in_word_i.from_state} < CHK'(NUM_STATES);
  assign sym_ok    = {1'b0, in_word_i.symbol}     < CHK'(NUM_SYMBOLS);
  assign last_col  = seed_q || (col_q == SW'(NUM_STATES - 1));
  assign last_row  = row_q == SW'(NUM_STATES - 1);
  assign last_issue = last_col && last_row;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (accept && is_sym_op) begin
          state_d = CTL_RUN;
        end
      end
      CTL_RUN: begin
        if (last_issue) begin
          state_d = CTL_DRAIN;
        end
      end
      CTL_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = CTL_COMMIT;
        end
      end
      CTL_COMMIT: begin
        state_d = CTL_REPORT;
      end
      CTL_REPORT: begin
        if (sts_i.out_free && last_row) begin
          state_d = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      CTL_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          cmd_o.wr_start  = (op == OP_LOAD_START) && to_ok;
          cmd_o.wr_trans  = (op == OP_LOAD_TRANS) && to_ok && from_ok;
          cmd_o.wr_emit   = (op == OP_LOAD_EMIT) && to_ok && sym_ok;
          cmd_o.latch_sym = is_sym_op;
        end
      end
      CTL_RUN: begin
        cmd_o.issue     = 1'b1;
        cmd_o.seed      = seed_q;
        cmd_o.first_col = col_q == '0;
        cmd_o.last_col  = last_col;
        cmd_o.row       = IDX_W'(row_q);
        cmd_o.col       = IDX_W'(col_q);
      end
      CTL_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      CTL_REPORT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_idx  = IDX_W'(row_q);
        cmd_o.out_last = last_row;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      seed_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        CTL_IDLE: begin
          if (accept && is_sym_op) begin
            row_q  <= '0;
            col_q  <= '0;
            seed_q <= op == OP_FIRST_SYM;
          end
        end
        CTL_RUN: begin
          // advance column, wrap into next row
          if (last_col) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        CTL_COMMIT: begin
          row_q <= '0;
        end
        CTL_REPORT: begin
          if (sts_i.out_free) begin
            row_q <= row_q + 1'b1;
          end
        end
        default: begin
          row_q <= row_q;
        end
      endcase
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register occupied");

  a_commit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_COMMIT) |-> !sts_i.pipe_busy)
    else $error("metrics committed with pipeline still busy");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_IDLE) |-> !sts_i.pipe_busy)
    else $error("pipeline active while idle");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == CTL_RUN) && last_issue) |=> (state_q == CTL_DRAIN) && sts_i.pipe_busy)
    else $error("sweep did not hand over to drain");

endmodule

// File: sv/hmm_viterbi_metric_update_core.sv
// A first-symbol word sweeps NUM_STATES state pairs and a next-symbol word all
// NUM_STATES*NUM_STATES pairs through the single add-compare-select pipeline, which
// visits one state pair a cycle; then follow pipeline drain, commit and one result word
// per state, and output stalls hold off the result words.
// One word is in work at a time. After reset all cost tables and path metrics read as
// unreachable at once; no clearing pass.
module hmm_viterbi_metric_update_core import hmmv_pkg::*; #(
  parameter int unsigned NUM_STATES  = 4,
  parameter int unsigned NUM_SYMBOLS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  cmd_t cmd;
  sts_t sts;

  hmmv_ctrl #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hmmv_datapath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// File: tb/hmm_viterbi_metric_update_core_tb.sv
// Testbench for hmm_viterbi_metric_update_core: directed table, then random load/symbol
// episodes, checked against the table's expected metrics or a min-plus path metric predictor kept in the bench.
// Depends on hmmv_pkg and the core RTL only.
module hmm_viterbi_metric_update_core_tb;
  import hmmv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_STATES  = 4;
  localparam int unsigned NUM_SYMBOLS = 4;
  localparam int unsigned SETTLE      = NUM_STATES * NUM_STATES + NUM_STATES + 16;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned TIMEOUT_NS  = 5_000_000;

  // Operation codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic [NUM_STATES*COST_W-1:0] ALL_UNREACH = {NUM_STATES{COST_INF}};

  typedef struct packed {
    in_word_t                        word;
    logic                            typed;
    logic [NUM_STATES*COST_W-1:0]    want;   // state 0 in the top slice
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_word_o;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int bad_words      = 0;

  logic [COST_W-1:0] start_tbl  [NUM_STATES];
  logic [COST_W-1:0] trans_tbl  [NUM_STATES*NUM_STATES];
  logic [COST_W-1:0] emit_tbl   [NUM_STATES*NUM_SYMBOLS];
  logic [COST_W-1:0] metric_now [NUM_STATES];
  out_word_t         metric_q   [$];
  dir_row_t          dir_tbl    [$];

  hmm_viterbi_metric_update_core #(
    .NUM_STATES (NUM_STATES),
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #TIMEOUT_NS;
    $display("hmm_viterbi_metric_update_core_tb NOT OK");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Saturate at the unreachable code
  function automatic logic [COST_W-1:0] cost_sum(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
    logic [COST_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    if (total[COST_W] || (&total[COST_W-1:0])) begin
      return COST_INF;
    end
    return total[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] emit_cost(input int unsigned st,
                                                  input logic [IDX_W-1:0] sym);
    if (sym >= NUM_SYMBOLS) begin
      return COST_INF;
    end
    return emit_tbl[st*NUM_SYMBOLS + sym];
  endfunction

  // Update the tables and metrics; return 1 if the word had any effect
  function automatic bit apply_word(input in_word_t w);
    logic [COST_W-1:0] best;
    logic [COST_W-1:0] cand;
    logic [COST_W-1:0] nxt [NUM_STATES];
    case (w.operation)
      OP_LOAD_START: begin
        if (w.to_state >= NUM_STATES) return 1'b0;
        start_tbl[w.to_state] = w.cost;
        return 1'b1;
      end
      OP_LOAD_TRANS: begin
        if (w.from_state >= NUM_STATES || w.to_state >= NUM_STATES) return 1'b0;
        trans_tbl[w.from_state*NUM_STATES + w.to_state] = w.cost;
        return 1'b1;
      end
      OP_LOAD_EMIT: begin
        if (w.to_state >= NUM_STATES || w.symbol >= NUM_SYMBOLS) return 1'b0;
        emit_tbl[w.to_state*NUM_SYMBOLS + w.symbol] = w.cost;
        return 1'b1;
      end
      OP_FIRST_SYM: begin
        for (int i = 0; i < NUM_STATES; i++) begin
          metric_now[i] = cost_sum(start_tbl[i], emit_cost(i, w.symbol));
        end
        return 1'b1;
      end
      OP_NEXT_SYM: begin
        for (int i = 0; i < NUM_STATES; i++) begin
          best = COST_INF;
          for (int j = 0; j < NUM_STATES; j++) begin
            cand = cost_sum(metric_now[j], trans_tbl[j*NUM_STATES + i]);
            if (cand < best) best = cand;
          end
          nxt[i] = cost_sum(best, emit_cost(i, w.symbol));
        end
        for (int i = 0; i < NUM_STATES; i++) begin
          metric_now[i] = nxt[i];
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_word(input in_word_t w, input logic typed,
                           input logic [NUM_STATES*COST_W-1:0] want, output bit took);
    out_word_t o;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    took = apply_word(w);
    if (w.operation == OP_FIRST_SYM || w.operation == OP_NEXT_SYM) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        o.state_index = i[IDX_W-1:0];
        o.metric      = typed ? want[(NUM_STATES-1-i)*COST_W +: COST_W] : metric_now[i];
        o.last        = (i == NUM_STATES - 1);
        metric_q.push_back(o);
      end
    end
  endtask

  // Hold the sender off until every result word is back, then let the core settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (metric_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic dir_row_t mk_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] from,
                                      input logic [IDX_W-1:0] to, input logic [IDX_W-1:0] sym,
                                      input logic [COST_W-1:0] cost, input logic typed,
                                      input logic [NUM_STATES*COST_W-1:0] want);
    dir_row_t r;
    r.word.operation  = op;
    r.word.from_state = from;
    r.word.to_state   = to;
    r.word.symbol     = sym;
    r.word.cost       = cost;
    r.typed           = typed;
    r.want            = want;
    return r;
  endfunction

  function automatic logic [COST_W-1:0] rand_cost();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COST_INF;
      2:       return COST_INF - COST_W'($urandom_range(1, 16));
      3:       return r[COST_W-1:0];
      default: return COST_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Mostly in-range loads; now and then an out-of-range index or a spare opcode
  function automatic in_word_t rand_load();
    in_word_t w;
    w.operation  = OP_W'($urandom_range(OP_LOAD_START, OP_LOAD_EMIT));
    w.from_state = IDX_W'(($urandom_range(0, 7) != 0) ? $urandom_range(0, NUM_STATES - 1)
                                                      : $urandom_range(0, 15));
    w.to_state   = IDX_W'(($urandom_range(0, 7) != 0) ? $urandom_range(0, NUM_STATES - 1)
                                                      : $urandom_range(0, 15));
    w.symbol     = IDX_W'(($urandom_range(0, 7) != 0) ? $urandom_range(0, NUM_SYMBOLS - 1)
                                                      : $urandom_range(0, 15));
    w.cost       = rand_cost();
    if ($urandom_range(0, 15) == 0) begin
      w.operation = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
    end
    return w;
  endfunction

  function automatic in_word_t rand_sym(input logic [OP_W-1:0] op);
    in_word_t w;
    w.operation  = op;
    w.from_state = IDX_W'($urandom_range(0, 15));
    w.to_state   = IDX_W'($urandom_range(0, 15));
    w.symbol     = IDX_W'(($urandom_range(0, 7) != 0) ? $urandom_range(0, NUM_SYMBOLS - 1)
                                                      : $urandom_range(0, 15));
    w.cost       = rand_cost();
    return w;
  endfunction

  // Episodes: a burst of loads, usually a first symbol, then a run of mostly next symbols
  task automatic run_phase(input int n_items);
    int  sent;
    int  steps;
    bit  took;
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(1, 8)) begin
        send_word(rand_load(), 1'b0, '0, took);
        sent += took;
      end
      if ($urandom_range(0, 7) != 0) begin
        send_word(rand_sym(OP_FIRST_SYM), 1'b0, '0, took);
        sent += took;
      end
      steps = $urandom_range(0, 6);
      repeat (steps) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(rand_load(), 1'b0, '0, took);
        end else begin
          send_word(rand_sym(OP_NEXT_SYM), 1'b0, '0, took);
        end
        sent += took;
      end
    end
  endtask

  always @(posedge clk_i) begin : check_out
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (metric_q.size() == 0) begin
        bad_words++;
        if (bad_words <= MAX_SHOWN) begin
          $display("unexpected word: state %0d metric %h last %b",
                   out_word_o.state_index, out_word_o.metric, out_word_o.last);
        end
      end else begin
        want = metric_q.pop_front();
        if (out_word_o.state_index !== want.state_index ||
            out_word_o.metric !== want.metric || out_word_o.last !== want.last) begin
          bad_words++;
          if (bad_words <= MAX_SHOWN) begin
            $display("mismatch: want state %0d metric %h last %b, got state %0d metric %h last %b",
                     want.state_index, want.metric, want.last,
                     out_word_o.state_index, out_word_o.metric, out_word_o.last);
          end
        end
      end
    end
  end

  initial begin : stim
    bit took;
    for (int i = 0; i < NUM_STATES; i++) begin
      start_tbl[i]  = COST_INF;
      metric_now[i] = COST_INF;
    end
    for (int i = 0; i < NUM_STATES*NUM_STATES; i++) trans_tbl[i] = COST_INF;
    for (int i = 0; i < NUM_STATES*NUM_SYMBOLS; i++) emit_tbl[i] = COST_INF;

    //                       op             from to  sym cost       typed want
    dir_tbl.push_back(mk_row(OP_NEXT_SYM,   0,  0,  0,  20'h00000, 1'b1, ALL_UNREACH));
    dir_tbl.push_back(mk_row(OP_FIRST_SYM,  0,  0,  0,  20'h00000, 1'b1, ALL_UNREACH));
    dir_tbl.push_back(mk_row(OP_LOAD_START, 0,  0,  0,  20'h00000, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_START, 0,  1,  0,  20'h00100, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_START, 0,  2,  0,  20'hFFFFE, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_EMIT,  0,  0,  0,  20'h00000, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_EMIT,  0,  1,  0,  20'h00200, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_EMIT,  0,  2,  0,  20'h00001, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_EMIT,  0,  3,  0,  20'h00000, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_FIRST_SYM,  0,  0,  0,  20'h00000, 1'b1,
                             {20'h00000, 20'h00300, COST_INF, COST_INF}));
    dir_tbl.push_back(mk_row(OP_LOAD_TRANS, 0,  0,  0,  20'h00010, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_TRANS, 0,  1,  0,  20'hFFFFE, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_TRANS, 1,  2,  0,  20'h00005, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_TRANS, 3,  3,  0,  20'h00000, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_START, 15, 15, 15, 20'h00000, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_TRANS, 15, 0,  0,  20'h00000, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_EMIT,  0,  0,  15, 20'h00000, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_EMIT,  0,  IDX_W'(NUM_STATES), 1, 20'h00000, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_NEXT_SYM,   0,  0,  0,  20'h00000, 1'b0, '0));
    dir_tbl.push_back(mk_row(OP_NEXT_SYM,   0,  0,  15, 20'h00000, 1'b1, ALL_UNREACH));
    dir_tbl.push_back(mk_row(OP_SPARE_5,    15, 15, 15, COST_INF,  1'b0, '0));
    dir_tbl.push_back(mk_row(OP_SPARE_6,    15, 15, 15, COST_INF,  1'b0, '0));
    dir_tbl.push_back(mk_row(OP_SPARE_7,    15, 15, 15, COST_INF,  1'b0, '0));
    dir_tbl.push_back(mk_row(OP_LOAD_EMIT,  0,  1,  3,  COST_INF,  1'b0, '0));
    dir_tbl.push_back(mk_row(OP_FIRST_SYM,  0,  0,  3,  20'h00000, 1'b1, ALL_UNREACH));

    send_gap_pct   = 13;
    recv_stall_pct = 58;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[k]) begin
      send_word(dir_tbl[k].word, dir_tbl[k].typed, dir_tbl[k].want, took);
    end
    run_phase(100);
    drain();

    send_gap_pct   = 58;
    recv_stall_pct = 13;
    run_phase(100);
    drain();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(100);
    drain();

    if (bad_words == 0) begin
      $display("hmm_viterbi_metric_update_core_tb OK");
    end else begin
      $display("hmm_viterbi_metric_update_core_tb NOT OK");
    end
    $finish;
  end

endmodule
